FILE: rtl/core/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg - shared definitions for the record sequence filter
// Field widths, counter constants, register indexes, the emission sequencer
// state type and a saturating increment helper.
// ----------------------------------------------------------------------------
package rsf_pkg;

   localparam int unsigned WORD_W             = 32;
   localparam int unsigned MAX_RECORD_DEFAULT = 16;

   // Configuration register file.
   localparam int unsigned CSR_DATA_W      = 5;
   localparam int unsigned CSR_INDEX_W     = 1;
   localparam int unsigned REC_LEN_W       = 5;
   localparam int unsigned CNT_OFF_W       = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_LEN     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_OFFSET = 1'd1;

   localparam logic [REC_LEN_W-1:0] REC_LEN_RESET = 5'd4;
   localparam logic [CNT_OFF_W-1:0] CNT_OFF_RESET = 4'd3;

   // Sequence counter carried in the top byte of the counter word.
   localparam logic [7:0] CNT_STEP = 8'd2;
   localparam logic [7:0] CNT_WRAP = 8'hB8;

   // Result kinds carried in tuser.
   localparam logic KIND_WORD    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_HELD,
      SEQ_CUR,
      SEQ_SUM
   } seq_state_type;

   function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
      return (v == {WORD_W{1'b1}}) ? v : v + {{(WORD_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

FILE: rtl/core/record_sequence_filter_core.sv
// ----------------------------------------------------------------------------
// record_sequence_filter_core - sequence counter check on fixed-length records
// Passes records whose counter byte follows the expected sequence, resyncs on
// a counter pair of 0 then 2, and closes each stream with a summary word.
// ----------------------------------------------------------------------------
// Output path: the first word of a passed record goes through the sequencer
//   state, the read data register and the output register to rsp_.
// Throughput: one input word per cycle while no result is due; a word that
//   releases results holds req_tready low while the emission sequencer reads
//   them out of the record memory at one word per cycle unless rsp_ stalls.
// Reset: synchronous, active high; clears all control state and restores the
//   register defaults. The record memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module record_sequence_filter_core #(
   parameter int unsigned MAX_RECORD = rsf_pkg::MAX_RECORD_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_we,
   input  logic [rsf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rsf_pkg::CSR_DATA_W-1:0]   csr_wdata,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // [31:0] data_word
   input  logic                             req_tlast,   // stream_end

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] out_word, [63:32] bad_records, [95:64] total_records
   output logic [95:0]                      rsp_tdata,
   output logic                             rsp_tlast,   // record_last
   output logic                             rsp_tuser    // kind
);

   // Position inside a record, length of a record, and memory address widths.
   // The memory holds two banks of one record each: the record being filled
   // and the record held back for one record of lookahead.
   localparam int unsigned PW    = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
   localparam int unsigned LW    = $clog2(MAX_RECORD + 1);
   localparam int unsigned AW    = PW + 1;
   localparam int unsigned DEPTH = 2 ** AW;
   localparam int unsigned WW    = rsf_pkg::WORD_W;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [rsf_pkg::REC_LEN_W-1:0] rec_len_ff;
   logic [rsf_pkg::CNT_OFF_W-1:0] cnt_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_len_ff <= rsf_pkg::REC_LEN_RESET;
         cnt_off_ff <= rsf_pkg::CNT_OFF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rsf_pkg::CSR_RECORD_LEN:     rec_len_ff <= csr_wdata[rsf_pkg::REC_LEN_W-1:0];
            rsf_pkg::CSR_COUNTER_OFFSET: cnt_off_ff <= csr_wdata[rsf_pkg::CNT_OFF_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective record length and counter position. A length of zero acts as
   // one, a length above MAX_RECORD acts as MAX_RECORD, and a counter
   // position past the record end acts as the last word of the record.
   logic [LW-1:0] rec_len;
   logic [PW-1:0] cnt_off;

   always_comb begin
      if (rec_len_ff == '0) begin
         rec_len = LW'(1);
      end else if (32'(rec_len_ff) > 32'(MAX_RECORD)) begin
         rec_len = LW'(MAX_RECORD);
      end else begin
         rec_len = LW'(rec_len_ff);
      end
      if (32'(cnt_off_ff) >= 32'(rec_len)) begin
         cnt_off = PW'(rec_len - LW'(1));
      end else begin
         cnt_off = PW'(cnt_off_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Stream state
   // ------------------------------------------------------------------------
   logic [PW-1:0] wpos_ff,     wpos_in;
   logic          hdr_seen_ff, hdr_seen_in;
   logic [7:0]    exp_cnt_ff,  exp_cnt_in;
   logic          in_sync_ff,  in_sync_in;
   logic          rsync_ff,    rsync_in;
   logic [WW-1:0] bad_ff,      bad_in;
   logic [WW-1:0] total_ff,    total_in;
   logic [7:0]    cnt_byte_ff, cnt_byte_in;
   logic          bank_ff,     bank_in;
   logic [WW-1:0] sum_bad_ff,  sum_bad_in;
   logic [WW-1:0] sum_tot_ff,  sum_tot_in;

   logic          req_fire;
   logic [7:0]    top;
   logic [7:0]    rec_cnt;
   logic [7:0]    exp_step;
   logic          emit_held;
   logic          emit_cur;
   logic          emit_sum;
   logic          mem_we;

   assign req_fire = req_tvalid && req_tready;
   assign top      = req_tdata[31:24];

   // One accepted word updates the stream state in a single pass, in the same
   // order as the checks are defined: seed, pending resync decision, then the
   // end-of-record verdict, then the end-of-stream summary.
   always_comb begin
      wpos_in     = wpos_ff;
      hdr_seen_in = hdr_seen_ff;
      exp_cnt_in  = exp_cnt_ff;
      in_sync_in  = in_sync_ff;
      rsync_in    = rsync_ff;
      bad_in      = bad_ff;
      total_in    = total_ff;
      cnt_byte_in = cnt_byte_ff;
      bank_in     = bank_ff;
      sum_bad_in  = sum_bad_ff;
      sum_tot_in  = sum_tot_ff;
      emit_held   = 1'b0;
      emit_cur    = 1'b0;
      emit_sum    = 1'b0;
      mem_we      = 1'b0;
      rec_cnt     = (wpos_ff == cnt_off) ? top : cnt_byte_ff;
      exp_step    = '0;

      if (req_fire) begin
         if (!hdr_seen_ff) begin
            // The header is never stored; it only seeds the counter when the
            // counter sits at the first record word.
            hdr_seen_in = 1'b1;
            if (cnt_off == '0) begin
               exp_cnt_in = top + rsf_pkg::CNT_STEP;
            end
         end else begin
            mem_we = 1'b1;
            if (wpos_ff == cnt_off) begin
               cnt_byte_in = top;
            end

            // Seed from stream word counter_offset while no record is done.
            if ((total_ff == '0) && !rsync_ff && (cnt_off != '0) &&
                (wpos_ff == cnt_off - PW'(1))) begin
               exp_cnt_in = top + rsf_pkg::CNT_STEP;
            end

            // The counter word of the record after a held one decides it.
            if (rsync_ff && (wpos_ff == cnt_off)) begin
               rsync_in = 1'b0;
               if (top == rsf_pkg::CNT_STEP) begin
                  emit_held  = 1'b1;
                  in_sync_in = 1'b1;
                  exp_cnt_in = rsf_pkg::CNT_STEP;
               end else begin
                  bad_in = rsf_pkg::sat_inc(bad_in);
               end
            end

            if ((LW'(wpos_ff) + LW'(1)) >= rec_len) begin
               wpos_in  = '0;
               total_in = rsf_pkg::sat_inc(total_ff);
               if (rec_cnt == exp_cnt_in) begin
                  in_sync_in = 1'b1;
                  emit_cur   = 1'b1;
                  exp_step   = exp_cnt_in + rsf_pkg::CNT_STEP;
                  exp_cnt_in = (exp_step == rsf_pkg::CNT_WRAP) ? '0 : exp_step;
               end else if (!in_sync_in && (rec_cnt == '0) && !req_tlast) begin
                  // Hold this record: its bank is frozen and the next record
                  // fills the other bank.
                  bank_in  = ~bank_ff;
                  rsync_in = 1'b1;
               end else begin
                  in_sync_in = 1'b0;
                  bad_in     = rsf_pkg::sat_inc(bad_in);
               end
            end else begin
               wpos_in = wpos_ff + PW'(1);
            end
         end

         if (req_tlast) begin
            // A hold that never saw its lookahead counts as bad.
            if (rsync_in) begin
               bad_in = rsf_pkg::sat_inc(bad_in);
            end
            emit_sum    = 1'b1;
            sum_bad_in  = bad_in;
            sum_tot_in  = total_in;
            wpos_in     = '0;
            hdr_seen_in = 1'b0;
            exp_cnt_in  = '0;
            in_sync_in  = 1'b0;
            rsync_in    = 1'b0;
            bad_in      = '0;
            total_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff     <= '0;
         hdr_seen_ff <= 1'b0;
         exp_cnt_ff  <= '0;
         in_sync_ff  <= 1'b0;
         rsync_ff    <= 1'b0;
         bad_ff      <= '0;
         total_ff    <= '0;
         bank_ff     <= 1'b0;
      end else begin
         wpos_ff     <= wpos_in;
         hdr_seen_ff <= hdr_seen_in;
         exp_cnt_ff  <= exp_cnt_in;
         in_sync_ff  <= in_sync_in;
         rsync_ff    <= rsync_in;
         bad_ff      <= bad_in;
         total_ff    <= total_in;
         bank_ff     <= bank_in;
      end
   end

   // Payload side registers need no reset.
   always_ff @(posedge clock) begin
      cnt_byte_ff <= cnt_byte_in;
      sum_bad_ff  <= sum_bad_in;
      sum_tot_ff  <= sum_tot_in;
   end

   // ------------------------------------------------------------------------
   // Emission sequencer
   // ------------------------------------------------------------------------
   // After a word that releases results, the sequencer walks the held bank
   // (if the held record passed), then the current bank (if the current record
   // passed), then issues the end-of-stream summary. Input is stalled until
   // all results are issued, so a bank is never overwritten until read out.
   rsf_pkg::seq_state_type seq_ff, seq_in;
   logic [PW-1:0] idx_ff,      idx_in;
   logic          pend_cur_ff, pend_cur_in;
   logic          pend_sum_ff, pend_sum_in;

   logic          slot_free;
   logic          move;
   logic          idx_last;
   logic          iss_valid;
   logic          iss_kind;
   logic          iss_last;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   logic          rdv_ff;
   logic          rd_kind_ff;
   logic          rd_last_ff;
   logic [WW-1:0] rd_bad_ff;
   logic [WW-1:0] rd_tot_ff;
   logic [WW-1:0] rd_data_ff;

   assign idx_last   = (LW'(idx_ff) + LW'(1)) == rec_len;
   assign move       = rdv_ff && (!rsp_tvalid || rsp_tready);
   assign slot_free  = !rdv_ff || move;
   assign req_tready = (seq_ff == rsf_pkg::SEQ_IDLE);

   // Next state.
   always_comb begin
      seq_in      = seq_ff;
      idx_in      = idx_ff;
      pend_cur_in = pend_cur_ff;
      pend_sum_in = pend_sum_ff;
      case (seq_ff)
         rsf_pkg::SEQ_IDLE: begin
            idx_in      = '0;
            pend_cur_in = emit_cur;
            pend_sum_in = emit_sum;
            if (emit_held) begin
               seq_in = rsf_pkg::SEQ_HELD;
            end else if (emit_cur) begin
               seq_in = rsf_pkg::SEQ_CUR;
            end else if (emit_sum) begin
               seq_in = rsf_pkg::SEQ_SUM;
            end
         end
         rsf_pkg::SEQ_HELD: begin
            if (slot_free) begin
               if (idx_last) begin
                  idx_in = '0;
                  if (pend_cur_ff) begin
                     seq_in = rsf_pkg::SEQ_CUR;
                  end else if (pend_sum_ff) begin
                     seq_in = rsf_pkg::SEQ_SUM;
                  end else begin
                     seq_in = rsf_pkg::SEQ_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + PW'(1);
               end
            end
         end
         rsf_pkg::SEQ_CUR: begin
            if (slot_free) begin
               if (idx_last) begin
                  idx_in = '0;
                  seq_in = pend_sum_ff ? rsf_pkg::SEQ_SUM : rsf_pkg::SEQ_IDLE;
               end else begin
                  idx_in = idx_ff + PW'(1);
               end
            end
         end
         rsf_pkg::SEQ_SUM: begin
            if (slot_free) begin
               seq_in = rsf_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = rsf_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Issue outputs. The held record sits in the bank that is not being filled.
   always_comb begin
      iss_valid = 1'b0;
      iss_kind  = rsf_pkg::KIND_WORD;
      iss_last  = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = {bank_ff, idx_ff};
      case (seq_ff)
         rsf_pkg::SEQ_HELD: begin
            rd_addr   = {~bank_ff, idx_ff};
            iss_valid = slot_free;
            rd_en     = slot_free;
            iss_last  = idx_last;
         end
         rsf_pkg::SEQ_CUR: begin
            iss_valid = slot_free;
            rd_en     = slot_free;
            iss_last  = idx_last;
         end
         rsf_pkg::SEQ_SUM: begin
            iss_valid = slot_free;
            iss_kind  = rsf_pkg::KIND_SUMMARY;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= rsf_pkg::SEQ_IDLE;
         idx_ff      <= '0;
         pend_cur_ff <= 1'b0;
         pend_sum_ff <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         idx_ff      <= idx_in;
         pend_cur_ff <= pend_cur_in;
         pend_sum_ff <= pend_sum_in;
      end
   end

   // ------------------------------------------------------------------------
   // Record memory: two banks, written by accepted words, read by the
   // sequencer. The read data register only loads on a read, so it also holds
   // a word while the output register is stalled.
   // ------------------------------------------------------------------------
   logic [WW-1:0] store_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[{bank_ff, wpos_ff}] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Read stage: tag bits and summary counts travel beside the memory data.
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
      end else if (iss_valid) begin
         rdv_ff <= 1'b1;
      end else if (move) begin
         rdv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (iss_valid) begin
         rd_kind_ff <= iss_kind;
         rd_last_ff <= iss_last;
         rd_bad_ff  <= sum_bad_ff;
         rd_tot_ff  <= sum_tot_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   logic          rsp_valid_ff;
   logic          rsp_kind_ff;
   logic          rsp_last_ff;
   logic [WW-1:0] rsp_word_ff;
   logic [WW-1:0] rsp_bad_ff;
   logic [WW-1:0] rsp_tot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // A summary carries zero in the word fields; a record word carries zero
   // in the count fields.
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_kind_ff <= rd_kind_ff;
         if (rd_kind_ff == rsf_pkg::KIND_SUMMARY) begin
            rsp_word_ff <= '0;
            rsp_last_ff <= 1'b0;
            rsp_bad_ff  <= rd_bad_ff;
            rsp_tot_ff  <= rd_tot_ff;
         end else begin
            rsp_word_ff <= rd_data_ff;
            rsp_last_ff <= rd_last_ff;
            rsp_bad_ff  <= '0;
            rsp_tot_ff  <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_tot_ff, rsp_bad_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

FILE: test/record_sequence_filter_core_test.sv
// ----------------------------------------------------------------------------
// record_sequence_filter_core_test - self-checking bench for the filter core
// Drives streams of header and record words with random gaps and back
// pressure. A scoreboard class predicts the passed record words and the
// end-of-stream summaries and checks every result word as it leaves the core.
// ----------------------------------------------------------------------------
module record_sequence_filter_core_test;

   localparam int unsigned MAX_REC      = 16;
   localparam int unsigned MEM_AW       = $clog2(2 * MAX_REC);
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned IDLE_PCT     = 29;
   localparam int unsigned PHASE_WORDS  = 18;
   localparam int unsigned PRINT_CAP    = 100;

   // One result word as the scoreboard sees it.
   typedef struct {
      logic        kind;
      logic [31:0] word;
      logic        last;
      logic [31:0] bad;
      logic [31:0] total;
   } filter_result_type;

   // The scoreboard keeps its own copy of the filter state and the two
   // registers. Every accepted input word is run through the predictor, which
   // queues the result words it releases; every result word leaving the core
   // is checked against the oldest queued one.
   class filter_scoreboard;
      logic [rsf_pkg::REC_LEN_W-1:0] rec_len_reg = rsf_pkg::REC_LEN_RESET;
      logic [rsf_pkg::CNT_OFF_W-1:0] cnt_off_reg = rsf_pkg::CNT_OFF_RESET;
      logic [31:0]          rec_mem [0:2*MAX_REC-1];
      int unsigned          word_pos;
      bit                   header_seen;
      logic [7:0]           next_count;
      bit                   synced;
      bit                   held;
      logic [31:0]          bad_total;
      logic [31:0]          record_total;
      filter_result_type    pending_q[$];
      int unsigned          fail_count;
      int unsigned          words_checked;
      int unsigned          summaries_checked;

      task report(string msg);
         fail_count++;
         if (fail_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
      endtask

      function void set_regs(logic [rsf_pkg::REC_LEN_W-1:0] len,
                             logic [rsf_pkg::CNT_OFF_W-1:0] off);
         rec_len_reg = len;
         cnt_off_reg = off;
      endfunction

      function int unsigned pending();
         return pending_q.size();
      endfunction

      function logic [31:0] bump(logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      function void queue_record(int unsigned base, int unsigned len);
         filter_result_type r;
         for (int unsigned k = 0; k < len; k++) begin
            r.kind  = rsf_pkg::KIND_WORD;
            r.word  = rec_mem[MEM_AW'(base + k)];
            r.last  = (k + 1 == len);
            r.bad   = '0;
            r.total = '0;
            pending_q.push_back(r);
         end
      endfunction

      function void clear_stream();
         word_pos     = 0;
         header_seen  = 0;
         next_count   = '0;
         synced       = 0;
         held         = 0;
         bad_total    = '0;
         record_total = '0;
      endfunction

      function void note_word(logic [31:0] w, logic stream_end);
         logic [7:0]        top;
         logic [7:0]        cnt;
         int unsigned       len;
         int unsigned       off;
         int unsigned       pos;
         filter_result_type r;
         top = w[31:24];
         len = (rec_len_reg == '0) ? 1 :
               (32'(rec_len_reg) > MAX_REC) ? MAX_REC : 32'(rec_len_reg);
         off = (32'(cnt_off_reg) >= len) ? len - 1 : 32'(cnt_off_reg);
         if (!header_seen) begin
            // The header seeds the sequence only when the counter sits at
            // record position zero, i.e. stream word zero.
            header_seen = 1;
            if (off == 0) next_count = top + rsf_pkg::CNT_STEP;
         end else begin
            pos = (word_pos >= MAX_REC) ? MAX_REC - 1 : word_pos;
            rec_mem[MEM_AW'(pos)] = w;
            if (record_total == 0 && !held && off > 0 && pos == off - 1)
               next_count = top + rsf_pkg::CNT_STEP;
            // A held zero-counter record is decided by the counter word of
            // the following record, before that record is complete.
            if (held && pos == off) begin
               held = 0;
               if (top == rsf_pkg::CNT_STEP) begin
                  queue_record(MAX_REC, len);
                  synced     = 1;
                  next_count = rsf_pkg::CNT_STEP;
               end else begin
                  bad_total = bump(bad_total);
               end
            end
            if (pos + 1 >= len) begin
               cnt          = rec_mem[MEM_AW'(off)][31:24];
               word_pos     = 0;
               record_total = bump(record_total);
               if (cnt == next_count) begin
                  synced = 1;
                  queue_record(0, len);
                  next_count = next_count + rsf_pkg::CNT_STEP;
                  if (next_count == rsf_pkg::CNT_WRAP) next_count = '0;
               end else if (!synced && cnt == 8'd0 && !stream_end) begin
                  for (int unsigned k = 0; k < MAX_REC; k++)
                     rec_mem[MEM_AW'(MAX_REC + k)] = rec_mem[MEM_AW'(k)];
                  held = 1;
               end else begin
                  synced    = 0;
                  bad_total = bump(bad_total);
               end
            end else begin
               word_pos = pos + 1;
            end
         end
         if (stream_end) begin
            if (held) bad_total = bump(bad_total);
            r.kind  = rsf_pkg::KIND_SUMMARY;
            r.word  = '0;
            r.last  = 1'b0;
            r.bad   = bad_total;
            r.total = record_total;
            pending_q.push_back(r);
            clear_stream();
         end
      endfunction

      task check_result(filter_result_type got);
         filter_result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result word kind=%0b data=%h", got.kind, got.word));
            return;
         end
         want = pending_q.pop_front();
         if (want.kind == rsf_pkg::KIND_SUMMARY) summaries_checked++;
         else words_checked++;
         if (got.kind !== want.kind)
            report($sformatf("kind %b, expected %b", got.kind, want.kind));
         if (got.word !== want.word)
            report($sformatf("out_word %h, expected %h", got.word, want.word));
         if (got.last !== want.last)
            report($sformatf("record_last %b, expected %b", got.last, want.last));
         if (got.bad !== want.bad)
            report($sformatf("bad_records %0d, expected %0d", got.bad, want.bad));
         if (got.total !== want.total)
            report($sformatf("total_records %0d, expected %0d", got.total, want.total));
      endtask
   endclass

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            csr_we     = 1'b0;
   logic [rsf_pkg::CSR_INDEX_W-1:0] csr_index  = rsf_pkg::CSR_RECORD_LEN;
   logic [rsf_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [95:0]                     rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;

   filter_scoreboard sb = new();

   // Stimulus bookkeeping shared by the driving tasks.
   logic [31:0]  stream_q[$];
   bit           steady        = 1'b0;
   int unsigned  hold_requests = 0;
   int unsigned  hold_served   = 0;
   int unsigned  hold_left     = 0;
   int unsigned  words_sent    = 0;
   int unsigned  streams_sent  = 0;
   int unsigned  settings_used = 0;
   int unsigned  cycle_count   = 0;

   record_sequence_filter_core #(
      .MAX_RECORD (MAX_REC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] data_word
      .req_tlast  (req_tlast),   // stream_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] out_word, [63:32] bad, [95:64] total
      .rsp_tlast  (rsp_tlast),   // record_last
      .rsp_tuser  (rsp_tuser)    // kind
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.pending());
         $display("FAIL record_sequence_filter_core");
         $finish;
      end
   end

   // Result side. Normally the ready line drops in about 29 percent of the
   // cycles. When the stimulus asks for it, the receiver holds off for a
   // long stretch so that the core runs out of buffer room and pushes back
   // on its input while the sender keeps offering words.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Every word accepted on the result side goes to the scoreboard. Values
   // read here are the ones present just before the edge.
   always @(posedge clock) begin
      filter_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind  = rsp_tuser;
         got.word  = rsp_tdata[31:0];
         got.last  = rsp_tlast;
         got.bad   = rsp_tdata[63:32];
         got.total = rsp_tdata[95:64];
         sb.check_result(got);
      end
   end

   // Offer one input word, with random gaps ahead of it, and return at the
   // edge where it is taken. The scoreboard learns of it at that edge.
   task automatic send_word(input logic [31:0] w, input logic stream_end);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= stream_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(w, stream_end);
      words_sent++;
   endtask

   // Send the words in stream_q; the last one closes the stream.
   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++)
         send_word(stream_q[i], i == stream_q.size() - 1);
      streams_sent++;
      stream_q.delete();
   endtask

   // Drop valid, wait for every expected result, then give the core a few
   // more cycles so that nothing is still in flight before a register write.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both registers are written back to back with the enable held high.
   task automatic write_regs(input logic [rsf_pkg::REC_LEN_W-1:0] len,
                             input logic [rsf_pkg::CNT_OFF_W-1:0] off);
      csr_we    <= 1'b1;
      csr_index <= rsf_pkg::CSR_RECORD_LEN;
      csr_wdata <= rsf_pkg::CSR_DATA_W'(len);
      @(posedge clock);
      csr_index <= rsf_pkg::CSR_COUNTER_OFFSET;
      csr_wdata <= rsf_pkg::CSR_DATA_W'(off);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_regs(len, off);
      settings_used++;
      @(posedge clock);
   endtask

   function automatic logic [7:0] count_after(logic [7:0] c);
      logic [7:0] n;
      n = c + rsf_pkg::CNT_STEP;
      return (n == rsf_pkg::CNT_WRAP) ? 8'd0 : n;
   endfunction

   // Build one stream for the current register setting. Most records carry
   // the counter that follows the sequence; the rest break it, drop out of
   // sync and come back through a zero-then-two pair, or try a zero that is
   // not followed by a two. Some streams end in a partial record.
   task automatic build_stream(input logic [rsf_pkg::REC_LEN_W-1:0] len_reg,
                               input logic [rsf_pkg::CNT_OFF_W-1:0] off_reg);
      int unsigned len;
      int unsigned off;
      int unsigned n_rec;
      int unsigned cut;
      int unsigned pick;
      logic [7:0]  seed;
      logic [7:0]  run_count;
      logic [7:0]  cnt;
      logic [7:0]  plan_q[$];
      logic [31:0] w;
      len = (len_reg == '0) ? 1 : (32'(len_reg) > MAX_REC) ? MAX_REC : 32'(len_reg);
      off = (32'(off_reg) >= len) ? len - 1 : 32'(off_reg);
      n_rec = (len > 8) ? $urandom_range(0, 3) : $urandom_range(0, 7);
      // Even seeds land on the wrap point; odd ones step past it.
      if ($urandom_range(99) < 20) seed = 8'($urandom);
      else seed = 8'($urandom_range(0, 8'h5B) * 2);
      run_count = seed + rsf_pkg::CNT_STEP;
      w = $urandom;
      if (off == 0) w[31:24] = seed;
      stream_q.push_back(w);
      for (int unsigned r = 0; r < n_rec; r++) begin
         if (plan_q.size() != 0) begin
            cnt = plan_q.pop_front();
         end else begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               cnt = run_count;
               run_count = count_after(run_count);
            end else if (pick < 75) begin
               cnt = 8'($urandom);
            end else if (pick < 88) begin
               // Break the sequence, then offer a resync pair.
               cnt = 8'($urandom);
               plan_q.push_back(8'd0);
               plan_q.push_back(rsf_pkg::CNT_STEP);
               run_count = rsf_pkg::CNT_STEP + rsf_pkg::CNT_STEP;
            end else if (pick < 94) begin
               cnt = 8'd0;
               plan_q.push_back(8'($urandom_range(3, 255)));
            end else begin
               run_count = count_after(run_count);
               cnt = run_count;
               run_count = count_after(run_count);
            end
         end
         for (int unsigned k = 0; k < len; k++) begin
            w = $urandom;
            if (k == off) w[31:24] = cnt;
            if (r == 0 && off > 0 && k == off - 1) w[31:24] = seed;
            stream_q.push_back(w);
         end
      end
      if (len > 1 && $urandom_range(99) < 20) begin
         cut = $urandom_range(1, len - 1);
         for (int unsigned k = 0; k < cut; k++) begin
            w = $urandom;
            if (k == off) w[31:24] = $urandom_range(1) ? rsf_pkg::CNT_STEP : run_count;
            stream_q.push_back(w);
         end
      end
   endtask

   // Register settings for the random part: the extremes of both registers,
   // a length of zero, lengths beyond the record store and offsets at or past
   // the record length, plus two drawn at random.
   logic [rsf_pkg::REC_LEN_W-1:0] len_set[14] = '{5'd4, 5'd0, 5'd1, 5'd2, 5'd3, 5'd0,
                                                  5'd5, 5'd16, 5'd16, 5'd31, 5'd20,
                                                  5'd8, 5'd0, 5'd0};
   logic [rsf_pkg::CNT_OFF_W-1:0] off_set[14] = '{4'd3, 4'd0, 4'd0, 4'd1, 4'd0, 4'd7,
                                                  4'd9, 4'd15, 4'd0, 4'd15, 4'd2,
                                                  4'd8, 4'd0, 4'd0};

   initial begin
      int unsigned phase_start;
      len_set[12] = 5'($urandom_range(1, 31));
      off_set[12] = 4'($urandom_range(0, 15));
      len_set[13] = 5'($urandom_range(1, 6));
      off_set[13] = 4'($urandom_range(0, 15));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. First the reset setting: one passing record whose
      // seed comes from the word just before the counter word.
      stream_q = '{32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h10AB_CDEF, 32'h1200_0001};
      send_stream();
      drain();

      // One-word records with the counter in the header position: the
      // sequence wraps at its limit, breaks, resyncs through a zero-then-two
      // pair with both records leaving together, and the stream ends on a
      // zero counter while out of sync.
      write_regs(5'd1, 4'd0);
      stream_q = '{32'hB400_0001, 32'hB6FF_FFFF, 32'h0000_0002, 32'h0200_0003,
                   32'h0900_0004, 32'h0055_AA55, 32'h02AA_55AA, 32'h5500_0007,
                   32'h0000_0008};
      send_stream();
      drain();

      // A header alone closes an empty stream.
      stream_q = '{32'h8000_0000};
      send_stream();
      drain();

      // Three-word records: a bad first record drops sync, a zero-counter
      // record is held, and the stream is cut short before the next counter
      // word, so the hold is counted bad and the partial record is dropped.
      write_regs(5'd3, 4'd2);
      stream_q = '{32'h0000_0000, 32'h0101_0101, 32'h4000_0000, 32'h5000_0000,
                   32'h7FFF_FFFF, 32'h8000_0001, 32'h00C3_3C00, 32'hFEDC_BA98,
                   32'h0123_4567};
      send_stream();
      drain();

      // Random part, one phase per register setting. Phase three runs with
      // no idling on either side; phase seven starts with a long hold-off on
      // the result side.
      for (int p = 0; p < 14; p++) begin
         write_regs(len_set[4'(p)], off_set[4'(p)]);
         steady = (p == 3);
         if (p == 7) hold_requests++;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            build_stream(len_set[4'(p)], off_set[4'(p)]);
            send_stream();
         end
         drain();
      end
      steady = 1'b0;

      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));

      $display("run covered %0d input words in %0d streams across %0d register settings",
               words_sent, streams_sent, settings_used);
      $display("checked %0d record words and %0d summaries, %0d mismatches",
               sb.words_checked, sb.summaries_checked, sb.fail_count);
      if (sb.fail_count == 0) begin
         $display("PASS record_sequence_filter_core");
      end else begin
         $display("FAIL record_sequence_filter_core");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rsf_pkg.sv
rtl/core/record_sequence_filter_core.sv
test/record_sequence_filter_core_test.sv
